// ===== design/aprq_pkg.sv =====
// Shared types and codes of the aging priority ready queue.
package aprq_pkg;

  localparam int IdW   = 8;
  localparam int PrioW = 7;
  localparam int TimeW = 8;
  localparam int StepW = 4;

  typedef struct packed {
    logic [IdW-1:0]   id;
    logic [PrioW-1:0] prio;
    logic [TimeW-1:0] time_left;
  } entry_t;

  // Operation carried in in_tuser.
  typedef enum logic {
    OP_ADD  = 1'b0,
    OP_TICK = 1'b1
  } opcode_t;

  // Result status carried in out_tuser.
  typedef enum logic [1:0] {
    ST_ADDED    = 2'd0,
    ST_FULL     = 2'd1,
    ST_SERVED   = 2'd2,
    ST_IDLE     = 2'd3
  } status_t;

  // Configuration register indexes.
  localparam logic CFG_AGING_STEP   = 1'b0;
  localparam logic CFG_PRIORITY_CAP = 1'b1;

  localparam logic [StepW-1:0] AGING_STEP_RST   = 4'd3;
  localparam logic [PrioW-1:0] PRIORITY_CAP_RST = 7'd99;

  // Command broadcast to every cell of the row.
  typedef enum logic [1:0] {
    CMD_HOLD     = 2'd0,
    CMD_ADD      = 2'd1,
    CMD_REMOVE   = 2'd2,
    CMD_REINSERT = 2'd3
  } cmd_e_t;

  typedef struct packed {
    cmd_e_t cmd;
    entry_t entry;
  } cell_cmd_t;

endpackage

// ===== design/aprq_cell.sv =====
// One slot of the sorted queue: holds an entry and trades it with its neighbors.
module aprq_cell (
  input  logic               clk,
  input  logic               rst_n,
  input  aprq_pkg::cell_cmd_t cmd_i,
  input  aprq_pkg::entry_t   left_entry_i,
  input  logic               left_valid_i,
  input  logic               left_after_i,
  input  aprq_pkg::entry_t   right_entry_i,
  input  logic               right_valid_i,
  output aprq_pkg::entry_t   entry_o,
  output logic               valid_o,
  output logic               after_o
);

  aprq_pkg::entry_t entry_r, entry_nxt;
  logic             valid_r, valid_nxt;

  // On an add the new word goes after this slot when this slot is valid and not larger.
  // On a reinsert the queue is viewed shifted left by one, so the right neighbor decides.
  always_comb begin
    if (cmd_i.cmd == aprq_pkg::CMD_ADD) begin
      after_o = valid_r && (entry_r.prio <= cmd_i.entry.prio);
    end else begin
      after_o = right_valid_i && (right_entry_i.prio <= cmd_i.entry.prio);
    end
  end

  always_comb begin
    entry_nxt = entry_r;
    valid_nxt = valid_r;
    unique case (cmd_i.cmd)
      aprq_pkg::CMD_HOLD: begin
      end
      aprq_pkg::CMD_ADD: begin
        if (!after_o) begin
          if (left_after_i) begin
            entry_nxt = cmd_i.entry;
            valid_nxt = 1'b1;
          end else begin
            entry_nxt = left_entry_i;
            valid_nxt = left_valid_i;
          end
        end
      end
      aprq_pkg::CMD_REMOVE: begin
        entry_nxt = right_entry_i;
        valid_nxt = right_valid_i;
      end
      aprq_pkg::CMD_REINSERT: begin
        if (after_o) begin
          entry_nxt = right_entry_i;
          valid_nxt = right_valid_i;
        end else if (left_after_i) begin
          entry_nxt = cmd_i.entry;
          valid_nxt = 1'b1;
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    entry_r <= entry_nxt;
  end

  assign entry_o = entry_r;
  assign valid_o = valid_r;

endmodule

// ===== design/aging_priority_ready_queue.sv =====
// Top level of the aging priority ready queue: control, output register and the cell row.
//
// A ready queue of up to QUEUE_DEPTH processes kept in ascending priority order in a
// row of cells, slot 0 holding the head. An add word (in_tuser = 0) inserts the
// process after every entry of equal or smaller priority value, or reports full. A
// tick word (in_tuser = 1) serves the head: it reports the head's id and priority,
// decrements its run time (a zero run time stays zero) and either drops the entry when
// nothing is left or ages its priority by aging_step, capped at priority_cap, and
// reinserts it. The add, remove or remove-and-reinsert is one shift step across the
// cell row, decided by a compare in each cell against the broadcast entry. Each input
// word yields exactly one output word, held in an output register; a new input word
// is taken in the same cycle the pending result is taken, so the block sustains one
// word per clock while the result stream is not stalled. Write configuration only
// while the block is idle.
module aging_priority_ready_queue #(
  parameter int QUEUE_DEPTH = 128
) (
  input  logic        clk,
  input  logic        rst_n,
  // input stream
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [23:0] in_tdata,   // proc_id[7:0], start_priority[14:8], run_time[22:15]
  input  logic        in_tuser,   // opcode[0]
  // result stream
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [23:0] out_tdata,  // served_id[7:0], served_priority[14:8],
                                  // time_left[22:15], finished[23]
  output logic [1:0]  out_tuser,  // status[1:0]
  // configuration
  input  logic        cfg_we,
  input  logic        cfg_addr,
  input  logic [6:0]  cfg_data
);

  localparam int CntW = $clog2(QUEUE_DEPTH + 1);
  localparam logic [CntW-1:0] CntFull = CntW'(QUEUE_DEPTH);

  // configuration registers
  logic [aprq_pkg::StepW-1:0] aging_step_r;
  logic [aprq_pkg::PrioW-1:0] priority_cap_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      aging_step_r   <= aprq_pkg::AGING_STEP_RST;
      priority_cap_r <= aprq_pkg::PRIORITY_CAP_RST;
    end else if (cfg_we) begin
      unique case (cfg_addr)
        aprq_pkg::CFG_AGING_STEP:   aging_step_r   <= cfg_data[aprq_pkg::StepW-1:0];
        aprq_pkg::CFG_PRIORITY_CAP: priority_cap_r <= cfg_data;
        default: begin
        end
      endcase
    end
  end

  // cell row wiring
  aprq_pkg::entry_t    cell_entry [QUEUE_DEPTH];
  logic [QUEUE_DEPTH-1:0] cell_valid;
  logic [QUEUE_DEPTH-1:0] cell_after;
  aprq_pkg::cell_cmd_t row_cmd;

  logic [CntW-1:0] count_r, count_nxt;
  logic            out_tvalid_r;
  logic [1:0]      status_r, status_nxt;
  logic [23:0]     result_r, result_nxt;

  logic             accept;
  aprq_pkg::entry_t in_entry;
  aprq_pkg::entry_t head;
  logic [aprq_pkg::TimeW-1:0] left_time;
  logic [aprq_pkg::PrioW:0]   aged_sum;
  logic [aprq_pkg::PrioW-1:0] aged_prio;

  // take a new word whenever the output register is free or being emptied
  assign in_tready = !out_tvalid_r || out_tready;
  assign accept    = in_tvalid && in_tready;

  assign in_entry.id        = in_tdata[7:0];
  assign in_entry.prio      = in_tdata[14:8];
  assign in_entry.time_left = in_tdata[22:15];

  assign head      = cell_entry[0];
  assign left_time = (head.time_left != '0) ? head.time_left - 8'd1 : '0;
  assign aged_sum  = {1'b0, head.prio} + {4'b0, aging_step_r};
  assign aged_prio = (aged_sum > {1'b0, priority_cap_r}) ? priority_cap_r
                                                          : aged_sum[aprq_pkg::PrioW-1:0];

  // decide the row command and the result word
  always_comb begin
    row_cmd.cmd   = aprq_pkg::CMD_HOLD;
    row_cmd.entry = in_entry;
    count_nxt     = count_r;
    status_nxt    = status_r;
    result_nxt    = result_r;
    if (accept) begin
      result_nxt = '0;
      if (aprq_pkg::opcode_t'(in_tuser) == aprq_pkg::OP_ADD) begin
        if (count_r == CntFull) begin
          status_nxt = aprq_pkg::ST_FULL;
        end else begin
          status_nxt  = aprq_pkg::ST_ADDED;
          row_cmd.cmd = aprq_pkg::CMD_ADD;
          count_nxt   = count_r + 1'b1;
        end
      end else if (count_r == '0) begin
        status_nxt = aprq_pkg::ST_IDLE;
      end else begin
        status_nxt          = aprq_pkg::ST_SERVED;
        result_nxt[7:0]     = head.id;
        result_nxt[14:8]    = head.prio;
        result_nxt[22:15]   = left_time;
        if (left_time == '0) begin
          // drop the finished head
          result_nxt[23] = 1'b1;
          row_cmd.cmd    = aprq_pkg::CMD_REMOVE;
          count_nxt      = count_r - 1'b1;
        end else begin
          // pull the head out and put it back with its aged priority
          row_cmd.cmd             = aprq_pkg::CMD_REINSERT;
          row_cmd.entry.id        = head.id;
          row_cmd.entry.prio      = aged_prio;
          row_cmd.entry.time_left = left_time;
        end
      end
    end
  end

  for (genvar i = 0; i < QUEUE_DEPTH; i++) begin : g_cell
    aprq_pkg::entry_t left_entry, right_entry;
    logic             left_valid, left_after, right_valid;

    if (i == 0) begin : g_first
      assign left_entry = '0;
      assign left_valid = 1'b0;
      assign left_after = 1'b1;
    end else begin : g_mid
      assign left_entry = cell_entry[i-1];
      assign left_valid = cell_valid[i-1];
      assign left_after = cell_after[i-1];
    end

    if (i == QUEUE_DEPTH - 1) begin : g_last
      assign right_entry = '0;
      assign right_valid = 1'b0;
    end else begin : g_inner
      assign right_entry = cell_entry[i+1];
      assign right_valid = cell_valid[i+1];
    end

    aprq_cell u_cell (
      .clk          (clk),
      .rst_n        (rst_n),
      .cmd_i        (row_cmd),
      .left_entry_i (left_entry),
      .left_valid_i (left_valid),
      .left_after_i (left_after),
      .right_entry_i(right_entry),
      .right_valid_i(right_valid),
      .entry_o      (cell_entry[i]),
      .valid_o      (cell_valid[i]),
      .after_o      (cell_after[i])
    );
  end

  // control state and output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r      <= '0;
      out_tvalid_r <= 1'b0;
    end else begin
      count_r <= count_nxt;
      if (accept) begin
        out_tvalid_r <= 1'b1;
      end else if (out_tready) begin
        out_tvalid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    status_r <= status_nxt;
    result_r <= result_nxt;
  end

  assign out_tvalid = out_tvalid_r;
  assign out_tuser  = status_r;
  assign out_tdata  = result_r;

endmodule
